>>> src/dws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_pkg
// Shared types, widths and helpers for the damped wave string step block.
// ----------------------------------------------------------------------------
package dws_pkg;

    // field widths
    localparam int DISP_W    = 24;
    localparam int IDX_W     = 6;
    localparam int COEF_W    = 16;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // q0.16 rounding
    localparam int FRAC_W     = 16;
    localparam int ROUND_HALF = 32768;

    // internal arithmetic widths
    localparam int LAP_W    = 26;
    localparam int BASE_W   = 26;
    localparam int PROD1_W  = LAP_W + COEF_W + 1;
    localparam int CTERM_W  = PROD1_W - FRAC_W;
    localparam int SUM_W    = 28;
    localparam int PROD2_W  = SUM_W + COEF_W + 1;
    localparam int SAT_IN_W = PROD2_W - FRAC_W;

    // displacement range
    localparam int DISP_MAX = 8388607;
    localparam int DISP_MIN = -8388608;

    // register reset values
    localparam logic [COEF_W-1:0] WAVE_SPEED_SQ_RESET = 16'd6554;
    localparam logic [COEF_W-1:0] DAMPING_RESET       = 16'd65274;

    // register select by address bit
    localparam logic REG_WAVE_SPEED_SQ = 1'b0;
    localparam logic REG_DAMPING       = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_COMMIT
    } dws_state_t;

    // per-cell control
    typedef struct packed {
        logic shift;
        logic push;
        logic commit;
        logic load;
    } dws_cell_ctrl_t;

    // point issued to the update unit
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             is_end;
    } dws_issue_t;

    // clamp to the displacement range
    function automatic logic signed [DISP_W-1:0] dws_sat(input logic signed [SAT_IN_W-1:0] v);
        logic signed [DISP_W-1:0] r;
        if (v > SAT_IN_W'(DISP_MAX)) begin
            r = DISP_W'(DISP_MAX);
        end
        else if (v < SAT_IN_W'(DISP_MIN)) begin
            r = DISP_W'(DISP_MIN);
        end
        else begin
            r = v[DISP_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> src/dws_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_if
// Valid/ready channels: tick with drive value in, point displacement out.
// ----------------------------------------------------------------------------
interface dws_tick_if
    import dws_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DISP_W-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

interface dws_point_if
    import dws_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic        [IDX_W-1:0]  point_index;
    logic signed [DISP_W-1:0] displacement;
    logic                     last_point;

    modport source (output valid, output point_index, output displacement, output last_point,
                    input ready);
    modport sink   (input valid, input point_index, input displacement, input last_point,
                    output ready);
endinterface

>>> src/damped_wave_string_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_wave_string_step
// Damped 1-D wave string: one tick per transaction, one result per point.
// ----------------------------------------------------------------------------
// Each tick transaction adds its drive to point 0 and then streams out the
// new displacement of every point in index order, last_point marking the
// final one. A tick passes an accept state, a run state in which the ring
// of point cells rotates one place per cycle past the single two-stage
// update unit unless the output stalls, a drain state that empties that
// unit, and a commit state in which all cells advance their time planes
// at once. The next tick is taken only after the last point of the current
// one has left. Output stalls hold the ring and the update unit.
// Registers (APB, write at address 0 or 4): wave_speed_sq and damping, both
// unsigned Q0.16; paddr[2] selects the register.
// ----------------------------------------------------------------------------
module damped_wave_string_step
    import dws_pkg::*;
#(
    parameter int NUM_POINTS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    dws_tick_if.sink           tick,
    dws_point_if.source        point
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_POINTS - 1);

    logic [COEF_W-1:0] wave_speed_sq_reg;
    logic [COEF_W-1:0] damping_reg;

    dws_state_t        state_reg;
    dws_state_t        state_next;
    logic [IDX_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  cnt_next;
    logic [IDX_W-1:0]  dcnt_reg;
    logic [IDX_W-1:0]  dcnt_next;
    logic signed [DISP_W-1:0] left_reg;

    logic              adv;
    logic              out_fire;
    logic              load_en;
    logic              shift_en;
    logic              commit_en;
    dws_issue_t        issue;
    logic signed [DISP_W-1:0] load_value;

    logic signed [DISP_W-1:0] cur_a  [NUM_POINTS];
    logic signed [DISP_W-1:0] prev_a [NUM_POINTS];
    logic signed [DISP_W-1:0] nxt_a  [NUM_POINTS];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_speed_sq_reg <= WAVE_SPEED_SQ_RESET;
            damping_reg       <= DAMPING_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_WAVE_SPEED_SQ: wave_speed_sq_reg <= pwdata[COEF_W-1:0];
                REG_DAMPING:       damping_reg       <= pwdata[COEF_W-1:0];
                default:           wave_speed_sq_reg <= wave_speed_sq_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[2])
            REG_WAVE_SPEED_SQ: prdata = PDATA_W'(wave_speed_sq_reg);
            REG_DAMPING:       prdata = PDATA_W'(damping_reg);
            default:           prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // handshake helpers
    assign adv        = !point.valid || point.ready;
    assign out_fire   = point.valid && point.ready;
    assign load_value = dws_sat(SAT_IN_W'(cur_a[0]) + SAT_IN_W'(tick.drive));

    // sequencer state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    // left neighbor of the point at the head of the ring
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            left_reg <= cur_a[0];
        end
    end

    // sequencer next state and controls
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        tick.ready   = 1'b0;
        load_en      = 1'b0;
        shift_en     = 1'b0;
        commit_en    = 1'b0;
        issue.valid  = 1'b0;
        issue.idx    = cnt_reg;
        issue.last   = (cnt_reg == LAST_IDX);
        issue.is_end = (cnt_reg == '0) || (cnt_reg == LAST_IDX);

        unique case (state_reg)
            ST_IDLE:
            begin
                tick.ready = 1'b1;
                if (tick.valid)
                begin
                    load_en    = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                issue.valid = 1'b1;
                if (adv)
                begin
                    shift_en = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_IDX)
                    begin
                        cnt_next   = '0;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_fire && (dcnt_reg == LAST_IDX))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                commit_en  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // delivered point count
        dcnt_next = dcnt_reg;
        if (out_fire)
        begin
            dcnt_next = (dcnt_reg == LAST_IDX) ? '0 : dcnt_reg + 1'b1;
        end
    end

    // ring of point cells
    for (genvar k = 0; k < NUM_POINTS; k++)
    begin : g_cell
        dws_cell_ctrl_t           ctrl;
        logic signed [DISP_W-1:0] right_cur;
        logic signed [DISP_W-1:0] right_prev;
        logic signed [DISP_W-1:0] push_in;

        assign ctrl.shift  = shift_en;
        assign ctrl.push   = out_fire;
        assign ctrl.commit = commit_en;
        assign ctrl.load   = load_en && (k == 0);

        if (k == NUM_POINTS - 1)
        begin : g_tail
            assign right_cur  = cur_a[0];
            assign right_prev = prev_a[0];
            assign push_in    = point.displacement;
        end
        else
        begin : g_body
            assign right_cur  = cur_a[k+1];
            assign right_prev = prev_a[k+1];
            assign push_in    = nxt_a[k+1];
        end

        dws_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .load_cur   (load_value),
            .right_cur  (right_cur),
            .right_prev (right_prev),
            .push_in    (push_in),
            .cur        (cur_a[k]),
            .prev       (prev_a[k]),
            .nxt        (nxt_a[k])
        );
    end

    // shared update unit at the head of the ring
    dws_update u_update (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .issue         (issue),
        .cur           (cur_a[0]),
        .prev          (prev_a[0]),
        .left          (left_reg),
        .right         (cur_a[1]),
        .wave_speed_sq (wave_speed_sq_reg),
        .damping       (damping_reg),
        .res_valid     (point.valid),
        .res_index     (point.point_index),
        .res_value     (point.displacement),
        .res_last      (point.last_point)
    );

endmodule

>>> src/dws_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_cell
// One string point: current and previous displacement in a rotating ring,
// plus a slot of the shift chain that collects the new displacements.
// ----------------------------------------------------------------------------
module dws_cell
    import dws_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dws_cell_ctrl_t           ctrl,
    input  logic signed [DISP_W-1:0] load_cur,
    input  logic signed [DISP_W-1:0] right_cur,
    input  logic signed [DISP_W-1:0] right_prev,
    input  logic signed [DISP_W-1:0] push_in,
    output logic signed [DISP_W-1:0] cur,
    output logic signed [DISP_W-1:0] prev,
    output logic signed [DISP_W-1:0] nxt
);

    logic signed [DISP_W-1:0] cur_reg;
    logic signed [DISP_W-1:0] prev_reg;
    logic signed [DISP_W-1:0] nxt_reg;

    // time planes: drive load, plane rotation, ring shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg  <= '0;
            prev_reg <= '0;
        end
        else
        begin
            priority if (ctrl.load)
            begin
                cur_reg <= load_cur;
            end
            else if (ctrl.commit)
            begin
                cur_reg  <= nxt_reg;
                prev_reg <= cur_reg;
            end
            else if (ctrl.shift)
            begin
                cur_reg  <= right_cur;
                prev_reg <= right_prev;
            end
            else
            begin
                cur_reg  <= cur_reg;
                prev_reg <= prev_reg;
            end
        end
    end

    // new-displacement chain
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            nxt_reg <= push_in;
        end
    end

    assign cur  = cur_reg;
    assign prev = prev_reg;
    assign nxt  = nxt_reg;

endmodule

>>> src/dws_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_update
// Two-stage update unit: laplacian times c^2, then damping and saturation.
// The second stage is the output register of the point channel.
// ----------------------------------------------------------------------------
module dws_update
    import dws_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  dws_issue_t               issue,
    input  logic signed [DISP_W-1:0] cur,
    input  logic signed [DISP_W-1:0] prev,
    input  logic signed [DISP_W-1:0] left,
    input  logic signed [DISP_W-1:0] right,
    input  logic        [COEF_W-1:0] wave_speed_sq,
    input  logic        [COEF_W-1:0] damping,
    output logic                     res_valid,
    output logic        [IDX_W-1:0]  res_index,
    output logic signed [DISP_W-1:0] res_value,
    output logic                     res_last
);

    logic signed [LAP_W-1:0]    lap;
    logic signed [PROD1_W-1:0]  prod1;
    logic signed [PROD1_W-1:0]  rnd1;
    logic signed [BASE_W-1:0]   base_next;

    logic                       s1_valid_reg;
    logic        [IDX_W-1:0]    s1_idx_reg;
    logic                       s1_last_reg;
    logic signed [BASE_W-1:0]   s1_base_reg;
    logic signed [CTERM_W-1:0]  s1_cterm_reg;

    logic signed [SUM_W-1:0]    sum;
    logic signed [PROD2_W-1:0]  prod2;
    logic signed [PROD2_W-1:0]  rnd2;
    logic signed [DISP_W-1:0]   value_next;

    logic                       res_valid_reg;
    logic        [IDX_W-1:0]    res_index_reg;
    logic signed [DISP_W-1:0]   res_value_reg;
    logic                       res_last_reg;

    // stage 1: laplacian, coupling term, 2*cur - prev
    always_comb
    begin
        if (issue.is_end)
        begin
            lap = '0;
        end
        else
        begin
            lap = LAP_W'(left) + LAP_W'(right) - (LAP_W'(cur) <<< 1);
        end
        prod1     = PROD1_W'(lap) * PROD1_W'($signed({1'b0, wave_speed_sq}));
        rnd1      = prod1 + PROD1_W'(ROUND_HALF);
        base_next = (BASE_W'(cur) <<< 1) - BASE_W'(prev);
    end

    // stage 2: damping, rounding, saturation
    always_comb
    begin
        sum        = SUM_W'(s1_base_reg) + SUM_W'(s1_cterm_reg);
        prod2      = PROD2_W'(sum) * PROD2_W'($signed({1'b0, damping}));
        rnd2       = prod2 + PROD2_W'(ROUND_HALF);
        value_next = dws_sat(rnd2[PROD2_W-1:FRAC_W]);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= issue.valid;
            res_valid_reg <= s1_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_idx_reg    <= issue.idx;
            s1_last_reg   <= issue.last;
            s1_base_reg   <= base_next;
            s1_cterm_reg  <= rnd1[PROD1_W-1:FRAC_W];
            res_index_reg <= s1_idx_reg;
            res_last_reg  <= s1_last_reg;
            res_value_reg <= value_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_index = res_index_reg;
    assign res_value = res_value_reg;
    assign res_last  = res_last_reg;

endmodule

>>> verif/tb_damped_wave_string_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_damped_wave_string_step
// Self-checking bench for the damped wave string step block: a tick stream
// with random drive values, random idling on both channels, and coefficient
// values switched between phases. A scoreboard keeps its own copy of the
// three displacement planes and predicts every point of every tick.
// ----------------------------------------------------------------------------
module tb_damped_wave_string_step;
    import dws_pkg::*;

    localparam int NUM_POINTS = 32;

    // one predicted point of a tick
    typedef struct {
        logic        [IDX_W-1:0]  idx;
        logic signed [DISP_W-1:0] disp;
        logic                     last;
    } point_update_t;

    class wave_scoreboard;
        logic signed [DISP_W-1:0]  planes [3][NUM_POINTS];
        int unsigned               phase;
        logic        [COEF_W-1:0]  c2;
        logic        [COEF_W-1:0]  damp;
        point_update_t             string_points [$];
        int                        errors;

        function new();
            foreach (planes[p, i]) planes[p][i] = '0;
            phase  = 0;
            c2     = WAVE_SPEED_SQ_RESET;
            damp   = DAMPING_RESET;
            errors = 0;
        endfunction

        function void set_coef(logic sel, logic [COEF_W-1:0] value);
            if (sel == REG_WAVE_SPEED_SQ) c2 = value;
            else damp = value;
        endfunction

        function int pending();
            return string_points.size();
        endfunction

        function logic signed [DISP_W-1:0] clamp_disp(longint v);
            if (v > longint'(DISP_MAX)) return DISP_W'(DISP_MAX);
            if (v < longint'(DISP_MIN)) return DISP_W'(DISP_MIN);
            return v[DISP_W-1:0];
        endfunction

        // q0.16 product, rounded to nearest with ties upward
        function longint mul_round(longint a, logic [COEF_W-1:0] q);
            longint p;
            p = a * longint'({1'b0, q}) + 64'sd32768;
            return p >>> 16;
        endfunction

        // accepted tick: apply drive, compute next plane, queue every point
        function void note_tick(logic signed [DISP_W-1:0] drive);
            int            ic;
            int            inx;
            int            ip;
            longint        cur;
            longint        prev;
            longint        lap;
            longint        sum;
            point_update_t pt;
            ic  = phase % 3;
            inx = (ic + 1) % 3;
            ip  = (ic + 2) % 3;
            planes[ic][0] = clamp_disp(longint'(planes[ic][0]) + longint'(drive));
            for (int i = 0; i < NUM_POINTS; i++) begin
                cur  = planes[ic][i];
                prev = planes[ip][i];
                lap  = 0;
                if (i != 0 && i != NUM_POINTS - 1) begin
                    lap = longint'(planes[ic][i-1]) + longint'(planes[ic][i+1]) - 2 * cur;
                end
                sum = 2 * cur + mul_round(lap, c2) - prev;
                planes[inx][i] = clamp_disp(mul_round(sum, damp));
                pt.idx  = i[IDX_W-1:0];
                pt.disp = planes[inx][i];
                pt.last = (i == NUM_POINTS - 1);
                string_points.insert(string_points.size(), pt);
            end
            phase = inx;
        endfunction

        // accepted result against the oldest prediction
        function void check_point(logic [IDX_W-1:0] idx,
                                  logic signed [DISP_W-1:0] disp, logic last);
            point_update_t pt;
            if (string_points.size() == 0) begin
                $display("%0t: unexpected point transaction idx=%0d disp=%0d last=%0b",
                         $time, idx, disp, last);
                errors++;
                return;
            end
            pt = string_points.pop_front();
            if (idx !== pt.idx) begin
                $display("%0t: point_index expected %0d actual %0d", $time, pt.idx, idx);
                errors++;
            end
            if (disp !== pt.disp) begin
                $display("%0t: displacement of point %0d expected %0d actual %0d",
                         $time, pt.idx, pt.disp, disp);
                errors++;
            end
            if (last !== pt.last) begin
                $display("%0t: last_point of point %0d expected %0b actual %0b",
                         $time, pt.idx, pt.last, last);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    bit                 tx_calm;
    bit                 rx_calm;
    int                 ticks_sent;

    dws_tick_if  tick_ch ();
    dws_point_if point_ch ();

    wave_scoreboard sb = new();

    damped_wave_string_step #(
        .NUM_POINTS (NUM_POINTS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tick    (tick_ch.sink),
        .point   (point_ch.source)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // monitor both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (tick_ch.valid && tick_ch.ready) begin
                sb.note_tick(tick_ch.drive);
            end
            if (point_ch.valid && point_ch.ready) begin
                sb.check_point(point_ch.point_index, point_ch.displacement,
                               point_ch.last_point);
            end
        end
    end

    // result receiver with random stalls
    initial
    begin
        int stall;
        point_ch.ready = 1'b0;
        @(negedge clk);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                point_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            point_ch.ready <= 1'b1;
            do @(posedge clk); while (!point_ch.valid);
            @(negedge clk);
        end
    end

    // register write with read-back
    task automatic reg_write(input logic sel, input logic [COEF_W-1:0] value);
        logic [PDATA_W-1:0] rb;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {sel, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rb = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rb !== PDATA_W'(value)) begin
            $display("%0t: read-back of register %0d expected %0d actual %0d",
                     $time, sel, value, rb);
            sb.errors++;
        end
        sb.set_coef(sel, value);
    endtask

    // hold the sender until every predicted point has come
    task automatic wait_idle();
        tick_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // one tick transaction after a random gap
    task automatic send_tick(input logic signed [DISP_W-1:0] drive);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.drive <= drive;
        do @(posedge clk); while (!tick_ch.ready);
        @(negedge clk);
        ticks_sent++;
    endtask

    function automatic logic signed [DISP_W-1:0] random_drive();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 4) return DISP_W'(int'($urandom_range(0, 32767)) - 16384);
        if (kind <= 6) return '0;
        if (kind <= 8) return DISP_W'($urandom);
        return $urandom_range(0, 1) ? DISP_W'(DISP_MAX) : DISP_W'(DISP_MIN);
    endfunction

    // coefficients for a random phase, extremes among them
    task automatic pick_coefs();
        logic [COEF_W-1:0] c2;
        logic [COEF_W-1:0] damp;
        case ($urandom_range(0, 6))
            0: begin c2 = WAVE_SPEED_SQ_RESET; damp = DAMPING_RESET; end
            1: begin c2 = '0;                  damp = '0;            end
            2: begin c2 = '1;                  damp = '1;            end
            3: begin c2 = '0;                  damp = '1;            end
            4: begin c2 = '1;                  damp = '0;            end
            5: begin c2 = COEF_W'($urandom);   damp = COEF_W'($urandom); end
            default: begin
                c2   = COEF_W'($urandom);
                damp = COEF_W'($urandom_range(64000, 65535));
            end
        endcase
        reg_write(REG_WAVE_SPEED_SQ, c2);
        reg_write(REG_DAMPING, damp);
    endtask

    // main stimulus
    initial
    begin
        logic signed [DISP_W-1:0] drives_a [7];
        logic signed [DISP_W-1:0] drives_b [8];
        int count;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tick_ch.valid = 1'b0;
        tick_ch.drive = '0;
        tx_calm       = 1'b0;
        rx_calm       = 1'b0;
        ticks_sent    = 0;
        drives_a = '{DISP_W'(DISP_MAX), '0, '0, DISP_W'(DISP_MIN), -24'sd1, 24'sd1, '0};
        drives_b = '{DISP_W'(DISP_MAX), DISP_W'(DISP_MAX), DISP_W'(DISP_MAX),
                     DISP_W'(DISP_MAX), DISP_W'(DISP_MIN), DISP_W'(DISP_MIN),
                     DISP_W'(DISP_MIN), DISP_W'(DISP_MIN)};
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // reset coefficients, extreme and small drives
        foreach (drives_a[k]) send_tick(drives_a[k]);
        wait_idle();

        // full coupling and no damping: saturation at both ends of the range
        reg_write(REG_WAVE_SPEED_SQ, '1);
        reg_write(REG_DAMPING, '1);
        foreach (drives_b[k]) send_tick(drives_b[k]);
        wait_idle();

        // zero damping kills everything, then a free string without coupling
        reg_write(REG_WAVE_SPEED_SQ, '0);
        reg_write(REG_DAMPING, '0);
        send_tick(DISP_W'(DISP_MIN));
        send_tick(DISP_W'(DISP_MAX));
        wait_idle();
        reg_write(REG_DAMPING, '1);
        send_tick(24'sd4096);
        send_tick('0);
        send_tick('0);
        wait_idle();

        // random phases
        while (ticks_sent < 320) begin
            pick_coefs();
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            count   = $urandom_range(8, 30);
            repeat (count) begin
                if ($urandom_range(0, 19) == 0) wait_idle();
                send_tick(random_drive());
            end
            wait_idle();
        end

        tx_calm = 1'b0;
        rx_calm = 1'b0;
        repeat (2 * NUM_POINTS + 8) @(posedge clk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end
        else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
